// ----- hdl/bhs_pkg.sv -----
// bhs_pkg: shared constants and functions for the block header sha256d hasher
// sha-256 round constants, initial hash and round helpers; no dependencies
`timescale 1ns / 1ps

package bhs_pkg;

  localparam int unsigned HdrBytes = 80;
  localparam int unsigned NumRounds = 64;
  localparam int unsigned NumCfgRegs = 8;
  localparam int unsigned CfgIdxW = 3;

  typedef logic [31:0] word_t;
  typedef word_t [15:0] sched_t;
  typedef word_t [7:0] hstate_t;

  localparam word_t RoundK [NumRounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam hstate_t InitH = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic word_t rotr(word_t x, int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t bswap(word_t x);
    bswap = {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  // one round; s[0] is a
  function automatic hstate_t sha_round(hstate_t s, word_t k, word_t w);
    word_t t1;
    word_t t2;
    hstate_t r;
    t1 = s[7] + (rotr(s[4], 6) ^ rotr(s[4], 11) ^ rotr(s[4], 25))
       + ((s[4] & s[5]) ^ (~s[4] & s[6])) + k + w;
    t2 = (rotr(s[0], 2) ^ rotr(s[0], 13) ^ rotr(s[0], 22))
       + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
    r[7] = s[6];
    r[6] = s[5];
    r[5] = s[4];
    r[4] = s[3] + t1;
    r[3] = s[2];
    r[2] = s[1];
    r[1] = s[0];
    r[0] = t1 + t2;
    sha_round = r;
  endfunction

  // shift the schedule window by one word
  function automatic sched_t sched_next(sched_t w);
    word_t s0;
    word_t s1;
    sched_t r;
    s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    for (int i = 0; i < 15; i++) begin
      r[i] = w[i+1];
    end
    r[15] = w[0] + s0 + w[9] + s1;
    sched_next = r;
  endfunction

endpackage

// ----- hdl/bhs_compress.sv -----
// bhs_compress: fully unrolled sha-256 compression, one round per register stage
// uses bhs_pkg; the chaining value travels with the block for the final add
`timescale 1ns / 1ps

module bhs_compress import bhs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  logic    valid_i,
  input  hstate_t chain_i,
  input  sched_t  block_i,
  input  logic [127:0] side_i,
  output logic    valid_o,
  output hstate_t hash_o,
  output logic [127:0] side_o
);

  logic    vld_q   [NumRounds+1];
  hstate_t st_q    [NumRounds+1];
  hstate_t chain_q [NumRounds+1];
  sched_t  w_q     [NumRounds+1];
  logic [127:0] side_q [NumRounds+1];

  assign vld_q[0]   = valid_i;
  assign st_q[0]    = chain_i;
  assign chain_q[0] = chain_i;
  assign w_q[0]     = block_i;
  assign side_q[0]  = side_i;

  for (genvar r = 0; r < NumRounds; r++) begin : g_round
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[r+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[r+1] <= vld_q[r];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[r+1]    <= sha_round(st_q[r], RoundK[r], w_q[r][0]);
        w_q[r+1]     <= sched_next(w_q[r]);
        chain_q[r+1] <= chain_q[r];
        side_q[r+1]  <= side_q[r];
      end
    end
  end

  // final add stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= vld_q[NumRounds];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 8; i++) begin
        hash_o[i] <= chain_q[NumRounds][i] + st_q[NumRounds][i];
      end
      side_o <= side_q[NumRounds];
    end
  end

endmodule

// ----- hdl/block_header_sha256d_hasher.sv -----
// block_header_sha256d_hasher: double sha-256 of an 80-byte block header
// uses bhs_pkg and bhs_compress (three compression pipelines in series)
`timescale 1ns / 1ps

// One header enters per clock cycle while in_stall_o is low. Three unrolled
// compression pipelines of 65 stages each (64 rounds plus the chaining add)
// run in series, followed by one output register. A stall on the output
// freezes the whole pipeline only while a digest waits on the output;
// in_stall_o is high exactly then, and an empty output never stalls.
// Configuration words are sampled when an item enters the first pipeline.

module block_header_sha256d_hasher import bhs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] block_version_i,
  input  logic [31:0] timestamp_i,
  input  logic [31:0] compact_target_i,
  input  logic [31:0] header_nonce_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] digest_word0_o,
  output logic [63:0] digest_word1_o,
  output logic [63:0] digest_word2_o,
  output logic [63:0] digest_word3_o
);

  logic [63:0] cfg_q [NumCfgRegs];
  logic en;
  word_t hb [20];
  sched_t blk1, blk2, blk3;
  logic v1, v2, v3;
  hstate_t h1, h2, h3;
  logic [127:0] tail1, tail2, unused3;

  assign en = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCfgRegs; i++) cfg_q[i] <= '0;
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // header as little-endian 32-bit words, then byte swapped to big-endian
  always_comb begin
    hb[0]  = bswap(block_version_i);
    for (int i = 0; i < NumCfgRegs; i++) begin
      hb[1+2*i] = bswap(cfg_q[i][31:0]);
      hb[2+2*i] = bswap(cfg_q[i][63:32]);
    end
    hb[17] = bswap(timestamp_i);
    hb[18] = bswap(compact_target_i);
    hb[19] = bswap(header_nonce_i);
    for (int i = 0; i < 16; i++) blk1[i] = hb[i];
  end

  bhs_compress u_c1 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .chain_i(InitH), .block_i(blk1),
    .side_i({hb[19], hb[18], hb[17], hb[16]}), .valid_o(v1), .hash_o(h1), .side_o(tail1)
  );

  always_comb begin
    for (int i = 0; i < 4; i++) blk2[i] = tail1[32*i +: 32];
    blk2[4] = 32'h80000000;
    for (int i = 5; i < 15; i++) blk2[i] = '0;
    blk2[15] = 32'(HdrBytes * 8);
  end

  bhs_compress u_c2 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v1), .chain_i(h1), .block_i(blk2),
    .side_i('0), .valid_o(v2), .hash_o(h2), .side_o(tail2)
  );

  always_comb begin
    for (int i = 0; i < 8; i++) blk3[i] = h2[i];
    blk3[8] = 32'h80000000;
    for (int i = 9; i < 15; i++) blk3[i] = '0;
    blk3[15] = 32'd256;
  end

  bhs_compress u_c3 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v2), .chain_i(InitH), .block_i(blk3),
    .side_i(tail2), .valid_o(v3), .hash_o(h3), .side_o(unused3)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= v3;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      digest_word0_o <= {bswap(h3[1]), bswap(h3[0])};
      digest_word1_o <= {bswap(h3[3]), bswap(h3[2])};
      digest_word2_o <= {bswap(h3[5]), bswap(h3[4])};
      digest_word3_o <= {bswap(h3[7]), bswap(h3[6])};
    end
  end

  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(digest_word0_o))
    else $error("result changed under stall");
  a_stall_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input accepted while pipeline frozen");
  a_free_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

endmodule

// ----- tb/testbench.sv -----
// testbench: self-checking bench for block_header_sha256d_hasher
// models the double sha-256 of the 80-byte header and checks every digest
// depends on bhs_pkg for the register index width only
`timescale 1ns / 1ps

module testbench;
  import bhs_pkg::*;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PREV0, REG_PREV1, REG_PREV2, REG_PREV3,
    REG_MERKLE0, REG_MERKLE1, REG_MERKLE2, REG_MERKLE3
  } reg_idx_e;

  typedef struct packed {
    logic [63:0] d0;
    logic [63:0] d1;
    logic [63:0] d2;
    logic [63:0] d3;
  } digest_t;

  localparam logic [31:0] ShaK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam logic [31:0] ShaIv [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [31:0] block_version_i = '0;
  logic [31:0] timestamp_i = '0;
  logic [31:0] compact_target_i = '0;
  logic [31:0] header_nonce_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [63:0] digest_word0_o, digest_word1_o, digest_word2_o, digest_word3_o;

  logic [63:0] job_words [8];
  digest_t expected_digests [$];
  int errors = 0;
  int headers_sent = 0;
  int digests_seen = 0;
  int cfg_writes = 0;
  bit quiet_mode = 1'b0;

  block_header_sha256d_hasher DUT (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [31:0] rr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void sha_compress(ref logic [31:0] h [8], input logic [7:0] blk [64]);
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = rr(w[i-15], 7) ^ rr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rr(w[i-2], 17) ^ rr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    v = h;
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ShaK[i] + w[i];
      t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) h[i] = h[i] + v[i];
  endfunction

  function automatic digest_t header_sha256d(logic [31:0] ver, logic [31:0] tim,
                                             logic [31:0] bits, logic [31:0] nonce);
    logic [7:0] hdr [80];
    logic [7:0] blk [64];
    logic [31:0] h [8];
    logic [7:0] mid [32];
    logic [255:0] flat;
    for (int i = 0; i < 4; i++) begin
      hdr[i] = ver[8*i +: 8];
      hdr[68+i] = tim[8*i +: 8];
      hdr[72+i] = bits[8*i +: 8];
      hdr[76+i] = nonce[8*i +: 8];
    end
    for (int r = 0; r < 8; r++)
      for (int i = 0; i < 8; i++) hdr[4+8*r+i] = job_words[r][8*i +: 8];
    h = ShaIv;
    for (int i = 0; i < 64; i++) blk[i] = hdr[i];
    sha_compress(h, blk);
    for (int i = 0; i < 64; i++) blk[i] = 8'h00;
    for (int i = 0; i < 16; i++) blk[i] = hdr[64+i];
    blk[16] = 8'h80;
    blk[62] = 8'h02;
    blk[63] = 8'h80;
    sha_compress(h, blk);
    for (int i = 0; i < 32; i++) mid[i] = h[i/4][24-8*(i%4) +: 8];
    h = ShaIv;
    for (int i = 0; i < 64; i++) blk[i] = 8'h00;
    for (int i = 0; i < 32; i++) blk[i] = mid[i];
    blk[32] = 8'h80;
    blk[62] = 8'h01;
    sha_compress(h, blk);
    for (int i = 0; i < 32; i++) flat[8*i +: 8] = h[i/4][24-8*(i%4) +: 8];
    return '{d0: flat[63:0], d1: flat[127:64], d2: flat[191:128], d3: flat[255:192]};
  endfunction

  function automatic bit take_gap();
    return !quiet_mode && ($urandom_range(99) < 22);
  endfunction

  task automatic write_job_word(reg_idx_e idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    job_words[idx] = val;
    cfg_writes++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_header(logic [31:0] ver, logic [31:0] tim,
                             logic [31:0] bits, logic [31:0] nonce);
    while (take_gap()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    block_version_i <= ver;
    timestamp_i <= tim;
    compact_target_i <= bits;
    header_nonce_i <= nonce;
    expected_digests.push_back(header_sha256d(ver, tim, bits, nonce));
    headers_sent++;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_digests.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic test_extremes();
    logic [31:0] pat [4] = '{32'h0, 32'hffffffff, 32'haaaaaaaa, 32'h55555555};
    for (int i = 0; i < 4; i++) send_header(pat[i], pat[i], pat[i], pat[i]);
    send_header(32'h20000000, 32'h5f5e1000, 32'h1d00ffff, 32'h7c2bac1d);
    drain();
  endtask

  task automatic test_job_words_extremes();
    for (int r = 0; r < 8; r++) write_job_word(reg_idx_e'(r), '1);
    for (int i = 0; i < 4; i++) send_header($urandom, $urandom, $urandom, $urandom);
    drain();
    for (int r = 0; r < 8; r++) write_job_word(reg_idx_e'(r), 64'h8000000000000001 << (r % 2));
    for (int i = 0; i < 4; i++) send_header($urandom, $urandom, $urandom, 32'hffffffff - i);
    drain();
  endtask

  task automatic test_random_jobs();
    for (int job = 0; job < 10; job++) begin
      for (int r = 0; r < 8; r++) write_job_word(reg_idx_e'(r), {$urandom, $urandom});
      quiet_mode = (job == 4);
      begin
        logic [31:0] ver, tim, bits, nonce;
        ver = $urandom; tim = $urandom; bits = $urandom; nonce = $urandom;
        for (int i = 0; i < 82; i++) begin
          // mostly a nonce sweep, with occasional fresh fields
          if ($urandom_range(9) == 0) begin
            ver = $urandom; tim = $urandom; bits = $urandom; nonce = $urandom;
          end
          send_header(ver, tim, bits, nonce);
          nonce++;
        end
      end
      quiet_mode = 1'b0;
      drain();
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) out_stall_i <= take_gap();
  end

  always @(posedge clk_i) begin
    digest_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      digests_seen++;
      if (expected_digests.size() == 0) begin
        $error("unexpected digest transfer");
        errors++;
      end else begin
        want = expected_digests.pop_front();
        if (digest_word0_o !== want.d0) begin
          $error("digest_word0 exp %h got %h", want.d0, digest_word0_o); errors++;
        end
        if (digest_word1_o !== want.d1) begin
          $error("digest_word1 exp %h got %h", want.d1, digest_word1_o); errors++;
        end
        if (digest_word2_o !== want.d2) begin
          $error("digest_word2 exp %h got %h", want.d2, digest_word2_o); errors++;
        end
        if (digest_word3_o !== want.d3) begin
          $error("digest_word3 exp %h got %h", want.d3, digest_word3_o); errors++;
        end
      end
    end
  end

  initial begin
    for (int r = 0; r < 8; r++) job_words[r] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_extremes();
    test_job_words_extremes();
    test_random_jobs();
    repeat (250) @(posedge clk_i);
    if (expected_digests.size() != 0) begin
      $error("%0d digests never arrived", expected_digests.size());
      errors++;
    end
    $display("%0d headers hashed, %0d digests checked, %0d job word writes",
             headers_sent, digests_seen, cfg_writes);
    if (errors == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

  initial begin
    #3000000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
